FILE: rtl/lognormal_rate_option_payoff_top_defines.svh
// Assertion macros used by the checker file of the lognormal rate payoff block.
`ifndef LOGNORMAL_RATE_OPTION_PAYOFF_TOP_DEFINES_SVH
`define LOGNORMAL_RATE_OPTION_PAYOFF_TOP_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define LROP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define LROP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lrop_pkg.sv
// Shared constants and codes of the lognormal rate payoff block.
package lrop_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_BITS = 28;
	localparam int TERMS = 13;
	localparam int IDX_W = 3;

	// ln 2 in Q.32, widened to the range-reduction width
	localparam logic [39:0] LN2_Q32 = 40'd2977044472;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_FWD_SCALE = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIFFUSION = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPREAD = 3'd3;
	localparam logic [IDX_W-1:0] REG_STRIKE = 3'd4;
	localparam logic [IDX_W-1:0] REG_DIG_AMOUNT = 3'd5;

	// payoff modes
	typedef enum logic [1:0] {
		MODE_CAPLET = 2'd0,
		MODE_FLOORLET = 2'd1,
		MODE_DIG_UP = 2'd2,
		MODE_DIG_DOWN = 2'd3
	} payoff_mode_t;

endpackage

FILE: rtl/lognormal_rate_option_payoff_top.sv
// Top level: pipelined lognormal forward rate and option payoff.
//
// channel   direction  signals
// -------   ---------  ---------------------------------------------
// input     in         in_valid, in_stall, state_value
// result    out        out_valid, out_stall, rate_value, payoff_value
// config    in         cfg_we, cfg_index, cfg_data
//
// One transaction enters per cycle while the result is not stalled.
// Depth is set by the Taylor series: 12 terms of multiply, reciprocal multiply, correct.
// A stalled result freezes the whole pipeline; in_stall follows out_valid and out_stall.
// arst_n clears valid bits and configuration; payload registers are not reset.
module lognormal_rate_option_payoff_top
	import lrop_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] state_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] rate_value,
	output logic signed [DATA_W-1:0] payoff_value
);

	// floor(2^32 / i) for the series divisors
	function automatic logic [31:0] recip(input int i);
		logic [31:0] m;
		begin
			case (i)
				2: m = 32'h80000000;
				3: m = 32'h55555555;
				4: m = 32'h40000000;
				5: m = 32'h33333333;
				6: m = 32'h2AAAAAAA;
				7: m = 32'h24924924;
				8: m = 32'h20000000;
				9: m = 32'h1C71C71C;
				10: m = 32'h19999999;
				11: m = 32'h1745D174;
				12: m = 32'h15555555;
				13: m = 32'h13B13B13;
				default: m = 32'hFFFFFFFF;
			endcase
			recip = m;
		end
	endfunction

	// clamp a wide signed value to the output range
	function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [38:0] v);
		logic signed [38:0] hi;
		logic signed [38:0] lo;
		begin
			hi = 39'sd2147483647;
			lo = -39'sd2147483648;
			if (v > hi) sat_out = hi[DATA_W-1:0];
			else if (v < lo) sat_out = lo[DATA_W-1:0];
			else sat_out = v[DATA_W-1:0];
		end
	endfunction

	// configuration registers
	payoff_mode_t       mode_q;
	logic [30:0]        fwd_scale_q;
	logic [30:0]        diffusion_q;
	logic signed [31:0] spread_q;
	logic signed [31:0] strike_q;
	logic signed [31:0] dig_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_CAPLET;
			fwd_scale_q  <= '0;
			diffusion_q  <= '0;
			spread_q     <= '0;
			strike_q     <= '0;
			dig_amount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= payoff_mode_t'(cfg_data[1:0]);
				REG_FWD_SCALE: fwd_scale_q <= cfg_data[30:0];
				REG_DIFFUSION: diffusion_q <= cfg_data[30:0];
				REG_SPREAD: spread_q <= cfg_data;
				REG_STRIKE: strike_q <= cfg_data;
				REG_DIG_AMOUNT: dig_amount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: whole pipeline holds while the result is stalled
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: diffusion * state
	logic signed [63:0] mul1;
	logic signed [62:0] p_s1;
	logic               vld_s1;
	assign mul1 = $signed({1'b0, diffusion_q}) * state_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) p_s1 <= mul1[62:0];
	end

	// stage 2: exponent argument in Q.32, offset by 128 ln2 to stay positive
	logic [39:0] xo_s2;
	logic        vld_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) xo_s2 <= {p_s1[62], p_s1[62:24]} + (LN2_Q32 << 7);
	end

	// stages 3-6: restoring division by ln2, two quotient bits per stage
	logic [39:0] dv_rem [0:4];
	logic [7:0]  dv_q   [0:4];
	logic        dv_vld [0:4];
	assign dv_rem[0] = xo_s2;
	assign dv_q[0]   = '0;
	assign dv_vld[0] = vld_s2;

	for (genvar j = 0; j < 4; j++) begin : g_div
		localparam logic [39:0] D_HI = LN2_Q32 << (7 - 2*j);
		localparam logic [39:0] D_LO = LN2_Q32 << (6 - 2*j);
		logic        ge_hi, ge_lo;
		logic [39:0] mid, fin;
		always_comb begin
			ge_hi = dv_rem[j] >= D_HI;
			mid   = ge_hi ? dv_rem[j] - D_HI : dv_rem[j];
			ge_lo = mid >= D_LO;
			fin   = ge_lo ? mid - D_LO : mid;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld[j+1] <= 1'b0;
			else if (adv) dv_vld[j+1] <= dv_vld[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem[j+1] <= fin;
				dv_q[j+1]   <= {dv_q[j][5:0], ge_hi, ge_lo};
			end
		end
	end

	// stage 7: series start, sum = 1 + r, term = r
	logic [31:0] tc_term [1:TERMS];
	logic [33:0] tc_sum  [1:TERMS];
	logic [31:0] tc_r    [1:TERMS];
	logic [7:0]  tc_k    [1:TERMS];
	logic        tc_vld  [1:TERMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tc_vld[1] <= 1'b0;
		else if (adv) tc_vld[1] <= dv_vld[4];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			tc_term[1] <= dv_rem[4][31:0];
			tc_sum[1]  <= {2'b01, 32'd0} + {2'b00, dv_rem[4][31:0]};
			tc_r[1]    <= dv_rem[4][31:0];
			tc_k[1]    <= dv_q[4];
		end
	end

	// Taylor terms 2..13: term*r, divide by i via reciprocal, correct and accumulate
	for (genvar i = 2; i <= TERMS; i++) begin : g_term
		localparam logic [31:0] M_I = recip(i);
		localparam logic [3:0]  I_C = 4'(i);
		logic [63:0] ta_prod;
		logic [33:0] ta_sum;
		logic [31:0] ta_r;
		logic [7:0]  ta_k;
		logic        ta_vld;
		logic [31:0] tb_v, tb_q0;
		logic [33:0] tb_sum;
		logic [31:0] tb_r;
		logic [7:0]  tb_k;
		logic        tb_vld;
		logic [63:0] mul_q;
		logic [35:0] rem;
		logic [31:0] quo;

		// multiply by r
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ta_vld <= 1'b0;
			else if (adv) ta_vld <= tc_vld[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ta_prod <= {32'd0, tc_term[i-1]} * {32'd0, tc_r[i-1]};
				ta_sum  <= tc_sum[i-1];
				ta_r    <= tc_r[i-1];
				ta_k    <= tc_k[i-1];
			end
		end

		// quotient estimate, low by at most one
		assign mul_q = {32'd0, ta_prod[63:32]} * {32'd0, M_I};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tb_vld <= 1'b0;
			else if (adv) tb_vld <= ta_vld;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				tb_v   <= ta_prod[63:32];
				tb_q0  <= mul_q[63:32];
				tb_sum <= ta_sum;
				tb_r   <= ta_r;
				tb_k   <= ta_k;
			end
		end

		// correction and accumulation
		always_comb begin
			rem = {4'd0, tb_v} - ({4'd0, tb_q0} * {32'd0, I_C});
			quo = (rem >= {32'd0, I_C}) ? tb_q0 + 32'd1 : tb_q0;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tc_vld[i] <= 1'b0;
			else if (adv) tc_vld[i] <= tb_vld;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				tc_term[i] <= quo;
				tc_sum[i]  <= tb_sum + {2'b00, quo};
				tc_r[i]    <= tb_r;
				tc_k[i]    <= tb_k;
			end
		end
	end

	// scale by 2^(k-4) into Q4.28 with rounding and saturation
	logic [31:0] e_se;
	logic        vld_se;
	logic [7:0]  rs;
	logic [34:0] rnd;
	logic [34:0] shv;
	logic [31:0] e_nxt;
	always_comb begin
		rs    = 8'd132 - tc_k[TERMS];
		rnd   = {1'b0, tc_sum[TERMS]} + (35'd1 << rs[5:0]) - ((35'd1 << rs[5:0]) >> 1);
		shv   = rnd >> rs[5:0];
		if (tc_k[TERMS] >= 8'd132) e_nxt = 32'hFFFFFFFF;
		else if (rs >= 8'd40) e_nxt = 32'd0;
		else if (shv[34:32] != 3'd0) e_nxt = 32'hFFFFFFFF;
		else e_nxt = shv[31:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_se <= 1'b0;
		else if (adv) vld_se <= tc_vld[TERMS];
	end
	always_ff @(posedge clk) begin
		if (adv) e_se <= e_nxt;
	end

	// forward_scale * E
	logic [62:0] prod_sm;
	logic [63:0] mul_f;
	logic        vld_sm;
	assign mul_f = {33'd0, fwd_scale_q} * {32'd0, e_se};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sm <= 1'b0;
		else if (adv) vld_sm <= vld_se;
	end
	always_ff @(posedge clk) begin
		if (adv) prod_sm <= mul_f[62:0];
	end

	// rate, kept wide
	logic [63:0]        prnd;
	logic signed [37:0] rate_sr;
	logic               vld_sr;
	assign prnd = {1'b0, prod_sm} + (64'd1 << (FRAC_BITS - 1));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sr <= 1'b0;
		else if (adv) vld_sr <= vld_sm;
	end
	always_ff @(posedge clk) begin
		if (adv) rate_sr <= $signed({2'b00, prnd[63:FRAC_BITS]}) + 38'(spread_q);
	end

	// payoff selection and output saturation
	logic signed [38:0] rate_w, strike_w, pay;
	always_comb begin
		rate_w   = 39'(rate_sr);
		strike_w = 39'(strike_q);
		case (mode_q)
			MODE_CAPLET: pay = (rate_w > strike_w) ? rate_w - strike_w : '0;
			MODE_FLOORLET: pay = (strike_w > rate_w) ? strike_w - rate_w : '0;
			MODE_DIG_UP: pay = (rate_w > strike_w) ? 39'(dig_amount_q) : '0;
			MODE_DIG_DOWN: pay = (rate_w < strike_w) ? 39'(dig_amount_q) : '0;
			default: pay = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_sr;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rate_value   <= sat_out(rate_w);
			payoff_value <= sat_out(pay);
		end
	end

endmodule

FILE: rtl/lrop_checker.sv
// Port-level checker for the lognormal rate payoff block, bound to the top level.
`include "lognormal_rate_option_payoff_top_defines.svh"

module lrop_checker
	import lrop_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [IDX_W-1:0]         cfg_index,
	input logic [DATA_W-1:0]        cfg_data,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic signed [DATA_W-1:0] state_value,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] rate_value,
	input logic signed [DATA_W-1:0] payoff_value
);

	// shadow of the mode and digital amount registers
	logic [1:0]        mode_q;
	logic [DATA_W-1:0] amount_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CAPLET;
			amount_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE) mode_q <= cfg_data[1:0];
			if (cfg_index == REG_DIG_AMOUNT) amount_q <= cfg_data;
		end
	end

	`LROP_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(rate_value) && $stable(payoff_value), "stalled result changed")
	`LROP_ASSERT_ALWAYS(a_stall_map, in_stall == (out_valid && out_stall), "input stall not tied to result stall")
	`LROP_ASSERT(a_vanilla_pos, out_valid && (mode_q == MODE_CAPLET || mode_q == MODE_FLOORLET) |-> !payoff_value[DATA_W-1], "negative vanilla payoff")
	`LROP_ASSERT(a_digital, out_valid && (mode_q == MODE_DIG_UP || mode_q == MODE_DIG_DOWN) |-> payoff_value == 0 || payoff_value == amount_q, "digital payoff not zero or amount")

endmodule

bind lognormal_rate_option_payoff_top lrop_checker u_lrop_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the lognormal forward rate and option payoff pipeline.
`timescale 1ns / 100ps

import lrop_pkg::*;

// Holds the register image, predicts rate and payoff per accepted sample, checks results.
class payoff_scoreboard;

	typedef struct {
		logic signed [31:0] rate;
		logic signed [31:0] payoff;
	} rate_payoff_t;

	payoff_mode_t       mode;
	bit [30:0]          fwd_scale;
	bit [30:0]          diffusion;
	bit signed [31:0]   spread;
	bit signed [31:0]   strike;
	bit signed [31:0]   dig_amount;
	rate_payoff_t       pending[$];
	int                 errors;
	int                 n_in;
	int                 n_out;

	function new();
		mode = MODE_CAPLET;
		fwd_scale = '0;
		diffusion = '0;
		spread = '0;
		strike = '0;
		dig_amount = '0;
		errors = 0;
		n_in = 0;
		n_out = 0;
	endfunction

	function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			REG_MODE: mode = payoff_mode_t'(data[1:0]);
			REG_FWD_SCALE: fwd_scale = data[30:0];
			REG_DIFFUSION: diffusion = data[30:0];
			REG_SPREAD: spread = data;
			REG_STRIKE: strike = data;
			REG_DIG_AMOUNT: dig_amount = data;
			default: ;
		endcase
	endfunction

	// exp of a Q.32 argument, as unsigned Q4.28 with saturation
	function bit [63:0] exp_q28(longint x);
		bit [63:0] ln2, xo, q, r, sum, term, v;
		int k, sh, rs;
		ln2 = 64'(LN2_Q32);
		xo = 64'(x) + 64'd128 * ln2;
		q = xo / ln2;
		r = xo - q * ln2;
		k = int'(q) - 128;
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int i = 1; i <= TERMS; i++) begin
			term = ((term * r) >> 32) / 64'(i);
			sum += term;
		end
		sh = k - 4;
		if (sh >= 0) begin
			if (sh > 31)
				return 64'hFFFF_FFFF;
			v = sum << sh;
		end else begin
			rs = -sh;
			if (rs >= 40)
				return 64'd0;
			v = (sum + (64'd1 << (rs - 1))) >> rs;
		end
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// predict the result of one accepted sample
	function void note_sample(logic signed [31:0] z);
		longint d, zz, p, x, rate, pay;
		bit [63:0] e, prod;
		rate_payoff_t res;
		d = longint'(diffusion);
		zz = z;
		p = d * zz;
		x = ((p + 64'sh4000_0000_0000_0000) >>> 24) - (64'sd1 <<< 38);
		e = exp_q28(x);
		prod = 64'(fwd_scale) * e;
		rate = longint'((prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS) + longint'(spread);
		case (mode)
			MODE_CAPLET: pay = (rate > strike) ? rate - strike : 0;
			MODE_FLOORLET: pay = (strike > rate) ? strike - rate : 0;
			MODE_DIG_UP: pay = (rate > strike) ? longint'(dig_amount) : 0;
			default: pay = (rate < strike) ? longint'(dig_amount) : 0;
		endcase
		res.rate = sat32(rate);
		res.payoff = sat32(pay);
		pending.push_back(res);
		n_in++;
	endfunction

	function void check_result(logic signed [31:0] rate, logic signed [31:0] payoff);
		rate_payoff_t exp_res;
		n_out++;
		if (pending.size() == 0) begin
			$error("result with nothing outstanding: rate %h payoff %h", rate, payoff);
			errors++;
			return;
		end
		exp_res = pending.pop_front();
		if (rate !== exp_res.rate) begin
			$error("rate_value: expected %h, got %h", exp_res.rate, rate);
			errors++;
		end
		if (payoff !== exp_res.payoff) begin
			$error("payoff_value: expected %h, got %h", exp_res.payoff, payoff);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import lrop_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 60;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] state_value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] rate_value;
	logic signed [DATA_W-1:0] payoff_value;

	payoff_scoreboard sb;
	bit               calm;
	int               idle_cycles;
	int               n_phases;

	lognormal_rate_option_payoff_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.state_value(state_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rate_value(rate_value),
		.payoff_value(payoff_value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly short gaps, a few long ones, none during calm stretches
	function int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (calm || sel < 65)
			return 0;
		if (sel < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sample state: mostly Gaussian-sized, some full range and extremes
	function logic signed [31:0] pick_state();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 1610612736) - 805306368;
			6, 7: return $urandom;
			8: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	// input-side transaction tracking
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_sample(state_value);
	end

	// result-side transaction check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(rate_value, payoff_value);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver stalls
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_state(logic signed [31:0] z);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		state_value <= z;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(logic [1:0] mode, logic [31:0] fwd, logic [31:0] diff,
			logic [31:0] spr, logic [31:0] stk, logic [31:0] amt);
		write_reg(REG_MODE, {30'd0, mode});
		write_reg(REG_FWD_SCALE, fwd);
		write_reg(REG_DIFFUSION, diff);
		write_reg(REG_SPREAD, spr);
		write_reg(REG_STRIKE, stk);
		write_reg(REG_DIG_AMOUNT, amt);
	endtask

	// drop valid and let the pipeline empty before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		n_phases++;
	endtask

	function logic [31:0] pick_fwd();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return $urandom;
			2: return 32'd0;
			default: return $urandom_range(0, 32'h0400_0000);
		endcase
	endfunction

	function logic [31:0] pick_diff();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return $urandom;
			default: return $urandom_range(0, 32'h0800_0000);
		endcase
	endfunction

	function logic [31:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0333_3333) - 32'h0199_9999;
		endcase
	endfunction

	initial begin
		logic [31:0] lvl;
		logic signed [31:0] corner_vals [0:6];
		sb = new();
		calm = 1'b0;
		idle_cycles = 0;
		n_phases = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		state_value = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset value
		send_state(32'sd0);
		send_state(32'sh1000_0000);
		drain();

		// field extremes, exp overflow and underflow, saturated rate
		load_regs(MODE_CAPLET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		corner_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd1, -32'sd1,
			32'sh1000_0000, -32'sh1000_0000};
		foreach (corner_vals[i])
			send_state(corner_vals[i]);
		drain();

		// floorlet with saturated payoff, ignored register indexes
		load_regs(MODE_FLOORLET, 32'h0100_0000, 32'h1000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h1234_5678);
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'hFFFF_FFFF);
		send_state(32'sh7FFF_FFFF);
		send_state(32'sh8000_0000);
		send_state(32'sh0800_0000);
		drain();

		// rate equal to strike: both digital modes pay nothing; then strikes one off the rate pay
		lvl = 32'h0147_AE14;
		load_regs(MODE_DIG_UP, 32'd0, 32'h0400_0000, lvl, lvl, 32'h8000_0000);
		send_state(32'sh1000_0000);
		send_state(-32'sh2000_0000);
		drain();
		write_reg(REG_MODE, {30'd0, MODE_DIG_DOWN});
		send_state(32'sh1000_0000);
		send_state(32'sh8000_0000);
		drain();
		write_reg(REG_DIG_AMOUNT, 32'h7FFF_FFFF);
		write_reg(REG_STRIKE, lvl + 32'd1);
		send_state(32'sd0);
		drain();
		write_reg(REG_MODE, {30'd0, MODE_DIG_UP});
		write_reg(REG_STRIKE, lvl - 32'd1);
		send_state(32'sd0);
		drain();

		// random phases cycling through every mode
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph % 4 == 3);
			load_regs(2'(ph % 4), pick_fwd(), pick_diff(), pick_level(), pick_level(),
				$urandom);
			repeat (95) send_state(pick_state());
			drain();
		end

		$display("covered %0d samples in %0d register settings, all four payoff modes,",
			sb.n_in, n_phases);
		$display("exp saturation both ways, rate/strike ties and %0d checked results", sb.n_out);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
